// ===== rtl/csv_line_field_splitter_assert.svh =====
// assertion macros shared by the csv splitter rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef CSV_LINE_FIELD_SPLITTER_ASSERT_SVH
`define CSV_LINE_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSVS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvs assertion failed");

// next-cycle implication, checked out of reset
`define CSVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvs assertion failed");

`endif

// ===== rtl/csvs_pkg.sv =====
// types and constants for the csv line field splitter
// no dependencies
package csvs_pkg;

    localparam logic [7:0] QUOTE_BYTE    = 8'h22;
    localparam logic [7:0] CR_BYTE       = 8'h0D;
    localparam logic [7:0] LF_BYTE       = 8'h0A;
    localparam logic [7:0] DEFAULT_DELIM = 8'h2C;
    localparam logic [7:0] FIELD_MAX     = 8'hFF;

    // result queue depth and derived widths
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_UNQUOTED = 4'b0001,
        MODE_QUOTED   = 4'b0010,
        MODE_QSEEN    = 4'b0100,
        MODE_DONE     = 4'b1000
    } mode_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       field_end;
        logic       record_end;
        logic [7:0] field_number;
        logic       run_last;
    } result_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] field_cnt;
    } parse_state_t;

    typedef struct packed {
        parse_state_t state_next;
        logic         prim_valid;
        result_t      prim;
        logic         fin_valid;
        result_t      fin;
    } step_out_t;

endpackage

// ===== rtl/csvs_step.sv =====
// per-byte parse step: next mode, next field count and up to two results
// depends on csvs_pkg
module csvs_step
    import csvs_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   in_byte,
    input  logic         line_last,
    input  logic [7:0]   delim,
    output step_out_t    step
);

    logic       is_quote;
    logic       treat_unquoted;
    logic       bump;
    logic [7:0] cnt_after;

    assign is_quote = (in_byte == QUOTE_BYTE);
    // a non-quote after a closing-quote candidate falls back to unquoted handling
    assign treat_unquoted = (state.mode == MODE_UNQUOTED) ||
                            ((state.mode == MODE_QSEEN) && !is_quote);

    always_comb
    begin
        mode_t      mode_mid;
        logic       p_valid;
        logic       p_char;
        logic [7:0] p_byte;

        mode_mid = state.mode;
        p_valid  = 1'b0;
        p_char   = 1'b0;
        p_byte   = 8'h00;
        bump     = 1'b0;

        if (treat_unquoted)
        begin
            mode_mid = MODE_UNQUOTED;
            priority if (is_quote)
            begin
                mode_mid = MODE_QUOTED;
            end
            else if (in_byte == delim)
            begin
                p_valid = 1'b1;
                bump    = 1'b1;
            end
            else if ((in_byte == CR_BYTE) || (in_byte == LF_BYTE))
            begin
                mode_mid = MODE_DONE;
            end
            else
            begin
                p_valid = 1'b1;
                p_char  = 1'b1;
                p_byte  = in_byte;
            end
        end
        else if (state.mode == MODE_QSEEN)
        begin
            // doubled quote
            mode_mid = MODE_QUOTED;
            p_valid  = 1'b1;
            p_char   = 1'b1;
            p_byte   = QUOTE_BYTE;
        end
        else if (state.mode == MODE_QUOTED)
        begin
            if (is_quote)
            begin
                mode_mid = MODE_QSEEN;
            end
            else
            begin
                p_valid = 1'b1;
                p_char  = 1'b1;
                p_byte  = in_byte;
            end
        end

        cnt_after = (bump && (state.field_cnt != FIELD_MAX)) ?
                    state.field_cnt + 8'd1 : state.field_cnt;

        step.prim_valid        = p_valid;
        step.prim.char_valid   = p_char;
        step.prim.out_char     = p_byte;
        step.prim.field_end    = !p_char;
        step.prim.record_end   = 1'b0;
        step.prim.field_number = state.field_cnt;
        step.prim.run_last     = !line_last;

        step.fin_valid         = line_last;
        step.fin.char_valid    = 1'b0;
        step.fin.out_char      = 8'h00;
        step.fin.field_end     = 1'b1;
        step.fin.record_end    = 1'b1;
        step.fin.field_number  = cnt_after;
        step.fin.run_last      = 1'b1;

        if (line_last)
        begin
            step.state_next.mode      = MODE_UNQUOTED;
            step.state_next.field_cnt = 8'd0;
        end
        else
        begin
            step.state_next.mode      = mode_mid;
            step.state_next.field_cnt = cnt_after;
        end
    end

endmodule

// ===== rtl/csvs_result_fifo.sv =====
// small result queue taking up to two words per cycle, giving one
// depends on csvs_pkg and the assertion macro header
`include "csv_line_field_splitter_assert.svh"

module csvs_result_fifo
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push_word0,
    input  result_t    push_word1,
    input  logic       pop,
    output result_t    head,
    output logic       not_empty,
    output logic       room2
);

    result_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [PTR_W-1:0]     wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != CNT_W'(0));
    assign room2     = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_word0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push_word1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CSVS_ASSERT_IMPL(a_no_overflow, push_cnt != 2'd0, count_next <= CNT_W'(QUEUE_DEPTH))
    `CSVS_ASSERT_IMPL(a_no_underflow, pop, not_empty)
    `CSVS_ASSERT_IMPL(a_ptr_gap, 1'b1, CNT_W'(PTR_W'(wr_ptr_reg - rd_ptr_reg)) == count_reg || count_reg == CNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/csv_line_field_splitter.sv =====
// CSV line field splitter: takes one line byte per word and gives field content
// bytes and field-end marks, one result word per cycle while out_ready is high.
// A byte is held in an input register, parsed in one pass and its results go
// into a four-word result queue. Sustained rate is one byte per clock while each
// byte yields at most one result and out_ready stays high; a line's last byte
// that also emits a content byte or a delimiter mark yields two words, the
// single-word output port being what limits it. Results reach the output from
// the input register through the result queue. The delimiter is written through
// cfg_write_en/delimiter_char and should only change while the block is idle.
// depends on csvs_pkg, csvs_step, csvs_result_fifo and the assertion macro header
`include "csv_line_field_splitter_assert.svh"

module csv_line_field_splitter
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] delimiter_char,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       field_end,
    output logic       record_end,
    output logic [7:0] field_number,
    output logic       run_last
);

    logic         hold_valid_reg;
    logic [7:0]   hold_byte_reg;
    logic         hold_last_reg;
    logic [7:0]   delim_reg;
    parse_state_t state_reg;
    step_out_t    step;
    logic         fire;
    logic         accept;
    logic         room2;
    logic         pop;
    logic [1:0]   push_cnt;
    result_t      push_word0;
    result_t      push_word1;
    result_t      head;

    // byte leaves the input register once the queue can take both results
    assign fire     = hold_valid_reg && room2;
    assign in_ready = !hold_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= line_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg       <= DEFAULT_DELIM;
            state_reg.mode  <= MODE_UNQUOTED;
            state_reg.field_cnt <= 8'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                delim_reg <= delimiter_char;
            end
            if (fire)
            begin
                state_reg <= step.state_next;
            end
        end
    end

    csvs_step u_step (
        .state     (state_reg),
        .in_byte   (hold_byte_reg),
        .line_last (hold_last_reg),
        .delim     (delim_reg),
        .step      (step)
    );

    // pack results so the first queue word is always the earlier one
    always_comb
    begin
        push_word0 = step.prim_valid ? step.prim : step.fin;
        push_word1 = step.fin;
        if (!fire)
        begin
            push_cnt = 2'd0;
        end
        else
        begin
            push_cnt = {1'b0, step.prim_valid} + {1'b0, step.fin_valid};
        end
    end

    assign pop = out_valid && out_ready;

    csvs_result_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_word0 (push_word0),
        .push_word1 (push_word1),
        .pop        (pop),
        .head       (head),
        .not_empty  (out_valid),
        .room2      (room2)
    );

    assign char_valid   = head.char_valid;
    assign out_char     = head.out_char;
    assign field_end    = head.field_end;
    assign record_end   = head.record_end;
    assign field_number = head.field_number;
    assign run_last     = head.run_last;

    `CSVS_ASSERT_NEXT(a_line_end_clears, fire && hold_last_reg, state_reg.field_cnt == 8'd0 && state_reg.mode == MODE_UNQUOTED)
    `CSVS_ASSERT_IMPL(a_record_end_closes, out_valid && record_end, field_end && run_last && !char_valid)
    `CSVS_ASSERT_IMPL(a_kind_exclusive, out_valid, char_valid != field_end)
    `CSVS_ASSERT_IMPL(a_fin_only_on_last, fire && step.fin_valid, hold_last_reg)

endmodule

// ===== tb/sv/csv_line_field_splitter_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for csv_line_field_splitter: drives line bytes with random gaps,
// predicts the field/record words and checks every output word as it is accepted
// depends on csvs_pkg and the csv_line_field_splitter rtl
module csv_line_field_splitter_tb
    import csvs_pkg::*;
();

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 1450;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic [7:0] delimiter_char;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       line_last;
    logic       out_valid;
    logic       out_ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_number;
    logic       run_last;

    // splitter state as the testbench sees it
    mode_t      mode_q  = MODE_UNQUOTED;
    logic [7:0] field_q = 8'd0;
    logic [7:0] delim_q = DEFAULT_DELIM;

    result_t    pending_words[$];
    int         fail_count  = 0;
    int         bytes_sent  = 0;
    int         live_bytes  = 0;
    int         lines_sent  = 0;
    int         words_seen  = 0;
    int         idle_cycles = 0;
    int         rx_hold     = 0;
    bit         tx_eager    = 1'b0;
    bit         rx_eager    = 1'b0;

    csv_line_field_splitter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .delimiter_char (delimiter_char),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .line_last      (line_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_valid     (char_valid),
        .out_char       (out_char),
        .field_end      (field_end),
        .record_end     (record_end),
        .field_number   (field_number),
        .run_last       (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic result_t make_word(logic cv, logic [7:0] ch, logic fe, logic re);
        result_t w;
        w.char_valid   = cv;
        w.out_char     = ch;
        w.field_end    = fe;
        w.record_end   = re;
        w.field_number = field_q;
        w.run_last     = 1'b0;
        return w;
    endfunction

    // a byte seen outside quotes
    task automatic unquoted_byte(input logic [7:0] b, ref result_t words[$]);
        if (b == QUOTE_BYTE)
            mode_q = MODE_QUOTED;
        else if (b == delim_q)
        begin
            words.push_back(make_word(1'b0, 8'h00, 1'b1, 1'b0));
            if (field_q != FIELD_MAX)
                field_q++;
        end
        else if (b == CR_BYTE || b == LF_BYTE)
            mode_q = MODE_DONE;
        else
            words.push_back(make_word(1'b1, b, 1'b0, 1'b0));
    endtask

    task automatic split_byte(input logic [7:0] b, input logic last);
        result_t words[$];
        bytes_sent++;
        if (mode_q != MODE_DONE)
            live_bytes++;
        case (mode_q)
            MODE_UNQUOTED:
                unquoted_byte(b, words);
            MODE_QUOTED:
                if (b == QUOTE_BYTE)
                    mode_q = MODE_QSEEN;
                else
                    words.push_back(make_word(1'b1, b, 1'b0, 1'b0));
            MODE_QSEEN:
                if (b == QUOTE_BYTE)
                begin
                    words.push_back(make_word(1'b1, QUOTE_BYTE, 1'b0, 1'b0));
                    mode_q = MODE_QUOTED;
                end
                else
                begin
                    mode_q = MODE_UNQUOTED;
                    unquoted_byte(b, words);
                end
            default:
                ;
        endcase
        if (last)
        begin
            words.push_back(make_word(1'b0, 8'h00, 1'b1, 1'b1));
            mode_q  = MODE_UNQUOTED;
            field_q = 8'd0;
        end
        if (words.size() > 0)
            words[words.size() - 1].run_last = 1'b1;
        foreach (words[k])
            pending_words.push_back(words[k]);
    endtask

    // called just after a rising edge; returns just after the edge that took the word
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        line_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        split_byte(b, last);
    endtask

    task automatic send_line(input logic [7:0] line[$]);
        foreach (line[k])
            send_byte(line[k], k == line.size() - 1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] line[$];
        for (int k = 0; k < s.len(); k++)
            line.push_back(s[k]);
        send_line(line);
    endtask

    // sender holds off until every predicted word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        wait_drained();
        cfg_write_en   <= 1'b1;
        delimiter_char <= d;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        delim_q = d;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == QUOTE_BYTE || c == delim_q || c == CR_BYTE || c == LF_BYTE);
        return c;
    endfunction

    task automatic test_directed();
        logic [7:0] line[$];
        send_text("a,c");
        send_text(",");
        send_text("\"x\"\"y\"");
        send_text("\"q\"z");
        send_text("\"u");
        send_text("a\"b");
        send_text("k\015\nj");
        line.push_back(8'h00);
        line.push_back(8'hFF);
        send_line(line);
    endtask

    task automatic test_delimiter_overlap();
        logic [7:0] line[$];
        // quote meaning wins over the delimiter
        set_delimiter(QUOTE_BYTE);
        send_text("a\"b\"c");
        // delimiter meaning wins over CR, LF still ends the line
        set_delimiter(CR_BYTE);
        send_text("a\015b\nc");
        set_delimiter(8'h00);
        line = {8'h78, 8'h00, 8'hFF};
        send_line(line);
        set_delimiter(8'hFF);
        line = {8'h00, 8'hFF, 8'h2C, 8'hFF};
        send_line(line);
        set_delimiter(DEFAULT_DELIM);
    endtask

    task automatic test_counter_saturation();
        logic [7:0] line[$];
        repeat (300)
            line.push_back(DEFAULT_DELIM);
        line.push_back("z");
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        send_line(line);
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    task automatic random_line();
        logic [7:0] line[$];
        int         nfields;
        int         kind;
        int         r;
        nfields = $urandom_range(1, 6);
        for (int f = 0; f < nfields; f++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                repeat ($urandom_range(0, 6))
                    line.push_back(plain_char());
            else if (kind < 8)
            begin
                line.push_back(QUOTE_BYTE);
                repeat ($urandom_range(0, 6))
                begin
                    r = $urandom_range(0, 19);
                    if (r < 2)
                    begin
                        line.push_back(QUOTE_BYTE);
                        line.push_back(QUOTE_BYTE);
                    end
                    else if (r == 2)
                        line.push_back(delim_q);
                    else if (r == 3)
                        line.push_back(($urandom_range(0, 1) != 0) ? CR_BYTE : LF_BYTE);
                    else
                        line.push_back(($urandom_range(0, 255) == QUOTE_BYTE)
                                       ? 8'h41 : 8'($urandom_range(0, 255)));
                end
                // an unterminated quote now and then
                if ($urandom_range(0, 15) != 0)
                    line.push_back(QUOTE_BYTE);
                if ($urandom_range(0, 19) == 0)
                    line.push_back(plain_char());
            end
            else
                repeat ($urandom_range(1, 5))
                    line.push_back(8'($urandom_range(0, 255)));
            if (f < nfields - 1)
                line.push_back(delim_q);
        end
        // line terminator with some trailing junk after it
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            if (r != 1)
                line.push_back(CR_BYTE);
            if (r != 0)
                line.push_back(LF_BYTE);
            repeat ($urandom_range(0, 3))
                line.push_back(8'($urandom_range(0, 255)));
        end
        if (line.size() == 0)
            line.push_back(8'($urandom_range(0, 255)));
        send_line(line);
    endtask

    task automatic test_random_lines();
        logic [7:0] delims[$];
        int         stop_at;
        int         n;
        delims  = {DEFAULT_DELIM, 8'h3B, 8'h09, 8'h7C, 8'h00, 8'hFF,
                   QUOTE_BYTE, CR_BYTE, LF_BYTE, 8'h20};
        stop_at = bytes_sent + RANDOM_BYTES;
        n = 0;
        while (bytes_sent < stop_at)
        begin
            if (n % 10 == 0)
                set_delimiter(delims[(n / 10) % delims.size()]);
            else if ($urandom_range(0, 19) == 0)
                wait_drained();
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);
            random_line();
            n++;
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // output side: random back-pressure and the word checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $error("output word with none predicted: char %0h field %0d",
                       out_char, field_number);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (char_valid !== want.char_valid)
                begin
                    $error("char_valid: expected %0d, got %0d", want.char_valid, char_valid);
                    fail_count++;
                end
                if (out_char !== want.out_char)
                begin
                    $error("out_char: expected %0h, got %0h", want.out_char, out_char);
                    fail_count++;
                end
                if (field_end !== want.field_end)
                begin
                    $error("field_end: expected %0d, got %0d", want.field_end, field_end);
                    fail_count++;
                end
                if (record_end !== want.record_end)
                begin
                    $error("record_end: expected %0d, got %0d", want.record_end, record_end);
                    fail_count++;
                end
                if (field_number !== want.field_number)
                begin
                    $error("field_number: expected %0d, got %0d",
                           want.field_number, field_number);
                    fail_count++;
                end
                if (run_last !== want.run_last)
                begin
                    $error("run_last: expected %0d, got %0d", want.run_last, run_last);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
        begin
            rx_hold   <= 0;
            out_ready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (rx_eager || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            rx_hold   <= pick_gap();
        end
    end

    // no word moving on either side for too long means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        delimiter_char <= DEFAULT_DELIM;
        in_valid       <= 1'b0;
        in_byte        <= 8'h00;
        line_last      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_delimiter_overlap();
        test_counter_saturation();
        test_random_lines();
        wait_drained();

        $display("sent %0d bytes (%0d parsed) in %0d lines, checked %0d output words",
                 bytes_sent, live_bytes, lines_sent, words_seen);
        $display("delimiters swept incl. quote, CR, LF, 0x00, 0xFF; field count saturated");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
